// ===== hdl/hsv_to_rgb_converter_macros.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// A property checked on every rising edge outside reset.
`define HSVRGB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property checked on every rising edge, including during reset.
`define HSVRGB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Constants, sector codes and shared types of the colour conversion pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    // One full turn of hue and one sector, in 1/64 degree.
    localparam logic [14:0] FULL_TURN   = 15'd23040;
    localparam logic [11:0] SECTOR_SPAN = 12'd3840;

    // A sector spans 15 steps of 256 hue units.
    localparam logic [6:0]  SECTOR_COARSE = 7'd15;

    // Full-scale fraction and the common denominator of q and t (255 * 3840).
    localparam logic [7:0]  UNIT   = 8'd255;
    localparam logic [19:0] DEN_QT = 20'd979200;

    // Reciprocal of 3825 scaled by 2^32; exact for numerators below 2^20.
    localparam logic [20:0] RECIP_QT       = 21'd1122868;
    localparam int          RECIP_QT_SHIFT = 32;

    // Reciprocal of 255 scaled by 2^24; exact for numerators up to 255 * 255.
    localparam logic [16:0] RECIP_UNIT       = 17'd65794;
    localparam int          RECIP_UNIT_SHIFT = 24;

    // The six hue sectors, named after the colours they run between.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW     = 3'd0,
        SEC_YELLOW_GREEN   = 3'd1,
        SEC_GREEN_CYAN     = 3'd2,
        SEC_CYAN_BLUE      = 3'd3,
        SEC_BLUE_MAGENTA   = 3'd4,
        SEC_MAGENTA_RED    = 3'd5
    } hsvrgb_sector_t;

    // Hue split into its sector and the position inside the sector.
    typedef struct packed {
        hsvrgb_sector_t sector;
        logic [11:0]    frac;
    } hsvrgb_split_t;

endpackage

// ===== hdl/hsvrgb_hue_split.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB hue splitter
// Wraps the hue into one turn and splits it into sector and fraction.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split
    import hsvrgb_pkg::*;
(
    input  logic [14:0]   hue,
    output hsvrgb_split_t split
);

    logic [14:0]    hue_wrapped;
    logic [6:0]     coarse;
    hsvrgb_sector_t sector;
    logic [14:0]    sector_base;
    logic [14:0]    frac_wide;

    // Hues of a full turn or more wrap once.
    assign hue_wrapped = (hue >= FULL_TURN) ? (hue - FULL_TURN) : hue;
    assign coarse      = hue_wrapped[14:8];

    // Since 3840 is 15 * 256, the sector follows from the top seven bits alone.
    always_comb
    begin
        priority if (coarse >= 7'(5 * SECTOR_COARSE))
            sector = SEC_MAGENTA_RED;
        else if (coarse >= 7'(4 * SECTOR_COARSE))
            sector = SEC_BLUE_MAGENTA;
        else if (coarse >= 7'(3 * SECTOR_COARSE))
            sector = SEC_CYAN_BLUE;
        else if (coarse >= 7'(2 * SECTOR_COARSE))
            sector = SEC_GREEN_CYAN;
        else if (coarse >= SECTOR_COARSE)
            sector = SEC_YELLOW_GREEN;
        else
            sector = SEC_RED_YELLOW;
    end

    // Start of the sector in hue units.
    always_comb
    begin
        unique case (sector)
            SEC_RED_YELLOW:   sector_base = 15'd0;
            SEC_YELLOW_GREEN: sector_base = 15'(SECTOR_SPAN);
            SEC_GREEN_CYAN:   sector_base = 15'(2 * SECTOR_SPAN);
            SEC_CYAN_BLUE:    sector_base = 15'(3 * SECTOR_SPAN);
            SEC_BLUE_MAGENTA: sector_base = 15'(4 * SECTOR_SPAN);
            SEC_MAGENTA_RED:  sector_base = 15'(5 * SECTOR_SPAN);
            default:          sector_base = 15'd0;
        endcase
    end

    // The remainder is always below one sector span.
    assign frac_wide    = hue_wrapped - sector_base;
    assign split.sector = sector;
    assign split.frac   = frac_wide[11:0];

endmodule

// ===== hdl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline that turns one HSV pixel into one truncated RGB pixel.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Fields
//  --------+--------------------+--------------------------------------------
//  input   | in_valid, in_stall | hue[14:0], saturation[7:0], brightness[7:0]
//  output  | out_valid,out_stall| red[7:0], green[7:0], blue[7:0]
//
//  A transaction is taken every cycle unless a finished result is held back;
//  it passes through the five register stages: hue split, first products,
//  brightness scaling, reciprocal division and sector selection.
//  A held-back result freezes every stage, so nothing is lost or repeated.
//  Reset clears the valid bits of all stages; payload registers keep no reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [14:0] hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic           advance;
    hsvrgb_split_t  split;

    // Valid bits of the five stages.
    logic           s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    // Stage 1: hue split.
    hsvrgb_sector_t s1_sector_reg;
    logic [11:0]    s1_frac_reg;
    logic [7:0]     s1_sat_reg;
    logic [7:0]     s1_bri_reg;

    // Stage 2: saturation products and numerators.
    logic [19:0]    s2_prod_q_next, s2_prod_t_next;
    logic [11:0]    s2_rest_next;
    hsvrgb_sector_t s2_sector_reg;
    logic [19:0]    s2_numer_q_reg, s2_numer_t_reg;
    logic [15:0]    s2_numer_p_reg;
    logic [7:0]     s2_bri_reg;

    // Stage 3: numerators scaled by brightness.
    hsvrgb_sector_t s3_sector_reg;
    logic [27:0]    s3_scaled_q_reg, s3_scaled_t_reg;
    logic [15:0]    s3_numer_p_reg;
    logic [7:0]     s3_bri_reg;

    // Stage 4: quotients.
    logic [40:0]    s4_prod_q_next, s4_prod_t_next;
    logic [32:0]    s4_prod_p_next;
    hsvrgb_sector_t s4_sector_reg;
    logic [7:0]     s4_q_reg, s4_t_reg, s4_p_reg, s4_v_reg;

    // Stage 5: output register.
    logic [7:0]     red_reg, green_reg, blue_reg;
    logic [7:0]     red_next, green_next, blue_next;

    // The whole pipeline moves unless a finished result is held back.
    assign advance  = !s5_valid_reg || !out_stall;
    assign in_stall = !advance;

    hsvrgb_hue_split u_hue_split
    (
        .hue   (hue),
        .split (split)
    );

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 2 products: sat * frac and sat * (span - frac).
    assign s2_rest_next   = SECTOR_SPAN - s1_frac_reg;
    assign s2_prod_q_next = 20'(s1_sat_reg) * 20'(s1_frac_reg);
    assign s2_prod_t_next = 20'(s1_sat_reg) * 20'(s2_rest_next);

    // Stage 4 divisions by 979200 and 255 through scaled reciprocals.
    // Division by 979200 drops the low eight bits first (979200 = 256 * 3825).
    assign s4_prod_q_next = 41'(s3_scaled_q_reg[27:8]) * 41'(RECIP_QT);
    assign s4_prod_t_next = 41'(s3_scaled_t_reg[27:8]) * 41'(RECIP_QT);
    assign s4_prod_p_next = 33'(s3_numer_p_reg) * 33'(RECIP_UNIT);

    // Stage 5 sector selection. Zero saturation gives p = q = t = v, so grey
    // needs no case of its own.
    always_comb
    begin
        unique case (s4_sector_reg)
            SEC_RED_YELLOW:
            begin
                red_next = s4_v_reg; green_next = s4_t_reg; blue_next = s4_p_reg;
            end
            SEC_YELLOW_GREEN:
            begin
                red_next = s4_q_reg; green_next = s4_v_reg; blue_next = s4_p_reg;
            end
            SEC_GREEN_CYAN:
            begin
                red_next = s4_p_reg; green_next = s4_v_reg; blue_next = s4_t_reg;
            end
            SEC_CYAN_BLUE:
            begin
                red_next = s4_p_reg; green_next = s4_q_reg; blue_next = s4_v_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next = s4_t_reg; green_next = s4_p_reg; blue_next = s4_v_reg;
            end
            default:
            begin
                red_next = s4_v_reg; green_next = s4_p_reg; blue_next = s4_q_reg;
            end
        endcase
    end

    // Payload registers of all stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sector_reg   <= split.sector;
            s1_frac_reg     <= split.frac;
            s1_sat_reg      <= saturation;
            s1_bri_reg      <= brightness;

            s2_sector_reg   <= s1_sector_reg;
            s2_numer_q_reg  <= DEN_QT - s2_prod_q_next;
            s2_numer_t_reg  <= DEN_QT - s2_prod_t_next;
            s2_numer_p_reg  <= 16'(s1_bri_reg) * 16'(UNIT - s1_sat_reg);
            s2_bri_reg      <= s1_bri_reg;

            s3_sector_reg   <= s2_sector_reg;
            s3_scaled_q_reg <= 28'(s2_bri_reg) * 28'(s2_numer_q_reg);
            s3_scaled_t_reg <= 28'(s2_bri_reg) * 28'(s2_numer_t_reg);
            s3_numer_p_reg  <= s2_numer_p_reg;
            s3_bri_reg      <= s2_bri_reg;

            s4_sector_reg   <= s3_sector_reg;
            s4_q_reg        <= 8'(s4_prod_q_next >> RECIP_QT_SHIFT);
            s4_t_reg        <= 8'(s4_prod_t_next >> RECIP_QT_SHIFT);
            s4_p_reg        <= 8'(s4_prod_p_next >> RECIP_UNIT_SHIFT);
            s4_v_reg        <= s3_bri_reg;

            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ===== hdl/hsvrgb_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter port checker
// Watches the converter's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [14:0] hue,
    input logic [7:0]  saturation,
    input logic [7:0]  brightness,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue
);

    // A held input transaction stays offered with the same pixel.
    `HSVRGB_ASSERT(a_in_held,
        in_valid && in_stall |=> in_valid && $stable({hue, saturation, brightness}),
        "input transaction changed while stalled")

    // A held result stays offered.
    `HSVRGB_ASSERT(a_out_valid_held, out_valid && out_stall |=> out_valid,
        "result dropped while stalled")

    // A held result keeps its colour.
    `HSVRGB_ASSERT(a_out_data_held,
        out_valid && out_stall |=> $stable({red, green, blue}),
        "result changed while stalled")

    // The input only waits while a finished result is held back.
    `HSVRGB_ASSERT(a_stall_only_when_full, in_stall |-> out_valid && out_stall,
        "input stalled with room in the pipeline")

    // No result is offered in the first cycle after reset.
    `HSVRGB_ASSERT_ALWAYS(a_empty_after_reset, !$past(rst_n) |-> !out_valid,
        "result offered straight after reset")

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (.*);
